// ===== rtl/rmvs_pkg.sv =====
// Shared types and constants for the running mean / variance / standard deviation block.
// Holds field widths, the controller state encoding and the datapath command set.
// No dependencies.
`default_nettype none

package rmvs_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 16;
	localparam int SUM_W    = SAMPLE_W + COUNT_W;
	localparam int SQ_W     = 2 * SAMPLE_W + COUNT_W - 1;
	localparam int MUL_W    = 32;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int MEAN_W   = 16;
	localparam int VAR_W    = 31;
	localparam int SD_W     = 16;

	// Iteration counts of the shared divider and the square root unit.
	localparam int MEAN_STEPS = 32;
	localparam int VAR_STEPS  = 31;
	localparam int SQRT_STEPS = 16;
	localparam int ITER_W     = 5;

	localparam logic [VAR_W-1:0] VAR_MAX = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MUL_SQ,
		ST_MUL_DEN,
		ST_MEAN_INIT,
		ST_MEAN_DIV,
		ST_MEAN_STORE,
		ST_VAR_INIT,
		ST_VAR_DIV,
		ST_VAR_STORE,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_UPDATE,
		DP_MUL_LO,
		DP_MUL_HI,
		DP_MUL_SQ,
		DP_MUL_DEN,
		DP_MEAN_INIT,
		DP_DIV_STEP,
		DP_MEAN_STORE,
		DP_VAR_INIT,
		DP_VAR_STORE,
		DP_SQRT_INIT,
		DP_SQRT_STEP,
		DP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic var_direct;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/rmvs_div.sv =====
// Restoring divider that produces one quotient bit per step.
// Loaded with a partial remainder, a dividend word and a divisor; uses rmvs_pkg.
`default_nettype none

module rmvs_div (
	input  wire logic                         clk,
	input  wire logic                         load,
	input  wire logic                         step,
	input  wire logic [rmvs_pkg::MUL_W-1:0]   rem_init,
	input  wire logic [rmvs_pkg::MUL_W-1:0]   quo_init,
	input  wire logic [rmvs_pkg::MUL_W-1:0]   divisor,
	output logic      [rmvs_pkg::MUL_W-1:0]   quo
);
	import rmvs_pkg::*;

	logic [MUL_W-1:0] rem_q;
	logic [MUL_W-1:0] quo_q;
	logic [MUL_W-1:0] dvs_q;
	logic [MUL_W:0]   trial;
	logic [MUL_W:0]   diff;
	logic             ge;

	// The dividend bits leave quo_q at the top while quotient bits enter at the bottom.
	assign trial = {rem_q, quo_q[MUL_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= rem_init;
			quo_q <= quo_init;
			dvs_q <= divisor;
		end else if (step) begin
			rem_q <= ge ? diff[MUL_W-1:0] : trial[MUL_W-1:0];
			quo_q <= {quo_q[MUL_W-2:0], ge};
		end
	end

	assign quo = quo_q;

endmodule

`default_nettype wire

// ===== rtl/rmvs_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per step.
// Sixteen steps give the floor root of a 31-bit word; uses rmvs_pkg.
`default_nettype none

module rmvs_sqrt (
	input  wire logic                         clk,
	input  wire logic                         load,
	input  wire logic                         step,
	input  wire logic [rmvs_pkg::VAR_W-1:0]   radicand,
	output logic      [rmvs_pkg::MUL_W-1:0]   root
);
	import rmvs_pkg::*;

	logic [MUL_W-1:0] v_q;
	logic [MUL_W-1:0] root_q;
	logic [VAR_W-1:0] bit_q;
	logic [MUL_W:0]   trial;
	logic             ge;

	assign trial = {1'b0, root_q} + {2'b0, bit_q};
	assign ge    = {1'b0, v_q} >= trial;

	always_ff @(posedge clk) begin
		if (load) begin
			v_q    <= {1'b0, radicand};
			root_q <= '0;
			bit_q  <= {1'b1, {(VAR_W-1){1'b0}}};
		end else if (step) begin
			if (ge) begin
				v_q    <= v_q - trial[MUL_W-1:0];
				root_q <= (root_q >> 1) + {1'b0, bit_q};
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = root_q;

endmodule

`default_nettype wire

// ===== rtl/rmvs_dp.sv =====
// Datapath: accumulators, one shared 32x32 multiplier, the divider and square root units,
// and the result registers. Driven by commands from rmvs_ctrl; uses rmvs_pkg.
`default_nettype none

module rmvs_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire rmvs_pkg::dp_cmd_t                  cmd,
	output rmvs_pkg::dp_status_t                    status,
	input  wire logic signed [rmvs_pkg::SAMPLE_W-1:0] sample,
	output logic signed [rmvs_pkg::MEAN_W-1:0]      mean,
	output logic        [rmvs_pkg::VAR_W-1:0]       variance,
	output logic        [rmvs_pkg::SD_W-1:0]        std_dev,
	output logic        [rmvs_pkg::COUNT_W-1:0]     count,
	output logic                                    full_res
);
	import rmvs_pkg::*;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic [COUNT_W-1:0]         count_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]            sumsq_q;
	logic                       full_q;

	logic [PROD_W-1:0]          prod_q;
	logic [PROD_W-1:0]          lhs_q;
	logic [PROD_W-1:0]          diff_q;
	logic                       gt_q;
	logic [MUL_W-1:0]           den_q;
	logic                       neg_q;
	logic [MEAN_W-1:0]          mean_q;
	logic [VAR_W-1:0]           var_q;

	logic [MEAN_W-1:0]          out_mean_q;
	logic [VAR_W-1:0]           out_var_q;
	logic [SD_W-1:0]            out_sd_q;
	logic [COUNT_W-1:0]         out_count_q;
	logic                       out_full_q;

	logic                       is_full;
	logic [SAMPLE_W-1:0]        abs_sample;
	logic [2*SAMPLE_W-1:0]      sq_sample;
	logic [SUM_W-1:0]           mag;
	logic [MUL_W-1:0]           mul_a;
	logic [MUL_W-1:0]           mul_b;
	logic [PROD_W-1:0]          mul_p;
	logic                       var_zero;
	logic                       var_sat;
	logic [MUL_W-1:0]           div_rem_init;
	logic [MUL_W-1:0]           div_quo_init;
	logic [MUL_W-1:0]           div_divisor;
	logic [MUL_W-1:0]           div_quo;
	logic [MUL_W-1:0]           sq_root;

	assign is_full    = count_q == '1;
	assign abs_sample = sample_q[SAMPLE_W-1] ? SAMPLE_W'(-sample_q) : SAMPLE_W'(sample_q);
	assign sq_sample  = abs_sample * abs_sample;
	assign mag        = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			DP_MUL_LO: begin
				mul_a = MUL_W'(count_q);
				mul_b = sumsq_q[MUL_W-1:0];
			end
			DP_MUL_HI: begin
				mul_a = MUL_W'(count_q);
				mul_b = MUL_W'(sumsq_q[SQ_W-1:MUL_W]);
			end
			DP_MUL_SQ: begin
				mul_a = mag;
				mul_b = mag;
			end
			DP_MUL_DEN: begin
				mul_a = MUL_W'(count_q);
				mul_b = MUL_W'(count_q - COUNT_W'(1));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// With the quotient known to fit in 31 bits, the top 32 dividend bits are already
	// below the divisor and can seed the remainder directly.
	assign var_zero          = (count_q < COUNT_W'(2)) || !gt_q;
	assign var_sat           = diff_q[2*MUL_W-2:VAR_W] >= den_q;
	assign status.var_direct = var_zero || var_sat;

	always_comb begin
		if (cmd.op == DP_MEAN_INIT) begin
			div_rem_init = '0;
			div_quo_init = mag;
			div_divisor  = MUL_W'(count_q);
		end else begin
			div_rem_init = diff_q[2*MUL_W-2:VAR_W];
			div_quo_init = {diff_q[VAR_W-1:0], 1'b0};
			div_divisor  = den_q;
		end
	end

	rmvs_div u_div (
		.clk      (clk),
		.load     ((cmd.op == DP_MEAN_INIT) || (cmd.op == DP_VAR_INIT)),
		.step     (cmd.op == DP_DIV_STEP),
		.rem_init (div_rem_init),
		.quo_init (div_quo_init),
		.divisor  (div_divisor),
		.quo      (div_quo)
	);

	rmvs_sqrt u_sqrt (
		.clk      (clk),
		.load     (cmd.op == DP_SQRT_INIT),
		.step     (cmd.op == DP_SQRT_STEP),
		.radicand (var_q),
		.root     (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			full_q  <= 1'b0;
		end else if (cmd.op == DP_UPDATE) begin
			full_q <= is_full;
			if (!is_full) begin
				count_q <= count_q + COUNT_W'(1);
				sum_q   <= sum_q + SUM_W'(sample_q);
				sumsq_q <= sumsq_q + SQ_W'(sq_sample);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				sample_q <= sample;
			end
			DP_MUL_LO: begin
				prod_q <= mul_p;
			end
			DP_MUL_HI: begin
				lhs_q  <= prod_q;
				prod_q <= mul_p;
			end
			DP_MUL_SQ: begin
				lhs_q  <= lhs_q + {prod_q[MUL_W-1:0], {MUL_W{1'b0}}};
				prod_q <= mul_p;
			end
			DP_MUL_DEN: begin
				diff_q <= lhs_q - prod_q;
				gt_q   <= lhs_q > prod_q;
				prod_q <= mul_p;
			end
			DP_MEAN_INIT: begin
				den_q <= prod_q[MUL_W-1:0];
				neg_q <= sum_q[SUM_W-1];
			end
			DP_MEAN_STORE: begin
				mean_q <= neg_q ? MEAN_W'(-div_quo) : div_quo[MEAN_W-1:0];
			end
			DP_VAR_INIT: begin
				if (var_zero) begin
					var_q <= '0;
				end else if (var_sat) begin
					var_q <= VAR_MAX;
				end
			end
			DP_VAR_STORE: begin
				var_q <= div_quo[VAR_W-1:0];
			end
			DP_OUT_LOAD: begin
				out_mean_q  <= mean_q;
				out_var_q   <= var_q;
				out_sd_q    <= sq_root[SD_W-1:0];
				out_count_q <= count_q;
				out_full_q  <= full_q;
			end
			default: begin
			end
		endcase
	end

	assign mean     = out_mean_q;
	assign variance = out_var_q;
	assign std_dev  = out_sd_q;
	assign count    = out_count_q;
	assign full_res = out_full_q;

	// The root of a 31-bit word always fits the 16-bit result.
	a_root_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_OUT_LOAD) |-> (sq_root[MUL_W-1:SD_W] == '0))
		else $error("square root wider than result field");

	// After any accumulate the count is at least one.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_UPDATE) |=> (count_q != '0))
		else $error("count zero after accumulate");

	// A variance that goes through the divider starts with a partial remainder below the divisor.
	a_div_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_VAR_INIT && !status.var_direct) |-> (diff_q[2*MUL_W-2:VAR_W] < den_q))
		else $error("variance divider seeded out of range");

endmodule

`default_nettype wire

// ===== rtl/rmvs_ctrl.sv =====
// Controller: sequences the datapath through accumulate, multiply, divide and square root,
// and owns the input and output handshakes. Uses rmvs_pkg.
`default_nettype none

module rmvs_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output rmvs_pkg::dp_cmd_t           cmd,
	input  wire rmvs_pkg::dp_status_t   status
);
	import rmvs_pkg::*;

	localparam logic [ITER_W-1:0] MEAN_LAST = ITER_W'(MEAN_STEPS - 1);
	localparam logic [ITER_W-1:0] VAR_LAST  = ITER_W'(VAR_STEPS - 1);
	localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(SQRT_STEPS - 1);

	state_t             state_q;
	state_t             state_d;
	logic [ITER_W-1:0]  iter_q;
	logic [ITER_W-1:0]  iter_d;
	logic               out_valid_q;
	logic               out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			iter_q      <= iter_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		iter_d      = '0;
		cmd.op      = DP_NOP;
		in_ready    = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = DP_LOAD;
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.op  = DP_UPDATE;
				state_d = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				cmd.op  = DP_MUL_LO;
				state_d = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.op  = DP_MUL_HI;
				state_d = ST_MUL_SQ;
			end
			ST_MUL_SQ: begin
				cmd.op  = DP_MUL_SQ;
				state_d = ST_MUL_DEN;
			end
			ST_MUL_DEN: begin
				cmd.op  = DP_MUL_DEN;
				state_d = ST_MEAN_INIT;
			end
			ST_MEAN_INIT: begin
				cmd.op  = DP_MEAN_INIT;
				state_d = ST_MEAN_DIV;
			end
			ST_MEAN_DIV: begin
				cmd.op = DP_DIV_STEP;
				iter_d = iter_q + ITER_W'(1);
				if (iter_q == MEAN_LAST) begin
					iter_d  = '0;
					state_d = ST_MEAN_STORE;
				end
			end
			ST_MEAN_STORE: begin
				cmd.op  = DP_MEAN_STORE;
				state_d = ST_VAR_INIT;
			end
			ST_VAR_INIT: begin
				// Zero or saturated variance needs no division.
				cmd.op  = DP_VAR_INIT;
				state_d = status.var_direct ? ST_SQRT_INIT : ST_VAR_DIV;
			end
			ST_VAR_DIV: begin
				cmd.op = DP_DIV_STEP;
				iter_d = iter_q + ITER_W'(1);
				if (iter_q == VAR_LAST) begin
					iter_d  = '0;
					state_d = ST_VAR_STORE;
				end
			end
			ST_VAR_STORE: begin
				cmd.op  = DP_VAR_STORE;
				state_d = ST_SQRT_INIT;
			end
			ST_SQRT_INIT: begin
				cmd.op  = DP_SQRT_INIT;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op = DP_SQRT_STEP;
				iter_d = iter_q + ITER_W'(1);
				if (iter_q == SQRT_LAST) begin
					iter_d  = '0;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// Wait until the result register is free.
				if (!out_valid_q || out_ready) begin
					cmd.op      = DP_OUT_LOAD;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished item not moved to the result register");

	a_mean_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MEAN_DIV && iter_q == MEAN_LAST) |=> (state_q == ST_MEAN_STORE))
		else $error("mean division did not end after its last step");

	a_var_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VAR_INIT && !status.var_direct) |=> (state_q == ST_VAR_DIV && iter_q == '0))
		else $error("variance division started with a stale step count");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result shown without a finished item");

endmodule

`default_nettype wire

// ===== rtl/running_mean_variance_stddev.sv =====
// Running mean, unbiased sample variance and standard deviation of signed Q8.8 samples.
// Top level: joins the controller rmvs_ctrl and the datapath rmvs_dp; uses rmvs_pkg.
//
// Each accepted item adds one sample to a count, a sum and a sum of squares, and yields one
// result item: the mean truncated toward zero (Q8.8), the variance (Q15.16, zero for a single
// sample, saturated at its field maximum), the floor square root of the variance (Q8.8), the
// count and a full flag. Once the count reaches 65535 further samples are ignored, the flag is
// set and the previous figures repeat. One item at a time is processed; the variance division is
// skipped when the variance needs no division (one sample, or a zero or saturated result). The
// work is done by one shared restoring divider (32 steps for the mean, 31 for the variance) and
// a 16-step square root unit, plus four passes through a single 32x32 multiplier. The result
// sits in an output register, so a new item is taken while the previous result still waits to
// be read.
`default_nettype none

module running_mean_variance_stddev (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [rmvs_pkg::SAMPLE_W-1:0] sample,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [rmvs_pkg::MEAN_W-1:0]        mean,
	output logic        [rmvs_pkg::VAR_W-1:0]         variance,
	output logic        [rmvs_pkg::SD_W-1:0]          std_dev,
	output logic        [rmvs_pkg::COUNT_W-1:0]       count,
	output logic                                      full_res
);
	import rmvs_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	rmvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	rmvs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.sample   (sample),
		.mean     (mean),
		.variance (variance),
		.std_dev  (std_dev),
		.count    (count),
		.full_res (full_res)
	);

endmodule

`default_nettype wire
